// ----- hdl/sbag_pkg.sv -----
// ----------------------------------------------------------------------------
// sbag_pkg
// Shared types, constants and helpers for the scaled blit address generator.
// ----------------------------------------------------------------------------
package sbag_pkg;

  localparam int MAX_DIM_DEF  = 4096;
  localparam int BPP_DEF      = 3;
  localparam int COORD_W      = 14;
  localparam int DIM_W        = 13;
  localparam int STRIDE_W     = 16;
  localparam int FMT_W        = 2;
  localparam int OFF_W        = 28;
  localparam int POS_W        = 14;
  localparam int PROD_W       = POS_W + STRIDE_W;
  localparam int QDEPTH       = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int STATUS_W     = 3;
  localparam int IN_DATA_W    = 8 * COORD_W;
  localparam int OUT_DATA_W   = 2 * OFF_W;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PAIR     = 3'd0,
    ST_STARTED  = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_IDLE     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    K_STEP,
    K_MISMATCH,
    K_EMPTY,
    K_START
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_SRC_STRIDE,
    REG_SRC_FORMAT,
    REG_DST_WIDTH,
    REG_DST_HEIGHT,
    REG_DST_STRIDE,
    REG_DST_FORMAT
  } reg_idx_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_ADDR
  } bstate_t;

  typedef struct packed {
    logic [DIM_W-1:0]    src_width;
    logic [DIM_W-1:0]    src_height;
    logic [STRIDE_W-1:0] src_stride;
    logic [FMT_W-1:0]    src_format;
    logic [DIM_W-1:0]    dst_width;
    logic [DIM_W-1:0]    dst_height;
    logic [STRIDE_W-1:0] dst_stride;
    logic [FMT_W-1:0]    dst_format;
  } cfg_t;

  // classified command, rectangles already clamped
  typedef struct packed {
    kind_t  kind;
    logic   copy;
    logic   rows_rev;
    logic   cols_rev;
    coord_t sl;
    coord_t st;
    coord_t sr;
    coord_t sb;
    coord_t dl;
    coord_t dt;
    coord_t dr;
    coord_t db;
  } entry_t;

  function automatic logic [DIM_W:0] dim_of(input logic [DIM_W-1:0] r,
                                            input int unsigned max_dim);
    if ({1'b0, r} > max_dim) return (DIM_W+1)'(max_dim);
    return {1'b0, r};
  endfunction

  function automatic coord_t clamp_lo(input coord_t x);
    if (x < 0) return '0;
    return x;
  endfunction

  function automatic coord_t clamp_hi(input coord_t x, input logic [DIM_W:0] dim);
    if ($signed({x[COORD_W-1], x}) >= $signed({1'b0, dim}))
      return coord_t'(dim - (DIM_W+1)'(1));
    return x;
  endfunction

endpackage

// ----- hdl/scaled_blit_address_generator.sv -----
// ----------------------------------------------------------------------------
// scaled_blit_address_generator
// Nearest-neighbor scaled blit: clamps rectangles, steps source and
// destination byte offsets per pixel.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      tdata: 8 corners, tuser: command, same_surface
//  m_*      out  tvalid/tready      tdata: src/dst offsets, tuser: status, tlast
//  cfg_*    in   cfg_valid/ready    cfg_index, cfg_data (always ready)
//
//  A pixel step passes through the back part as a multiply, then an add;
//  same-surface starts, rejected starts and idle steps finish in the idle
//  state. A scaling start holds the back part in its divide state while
//  two restoring dividers form the width and height ratios.
//  Reset restores the register defaults and leaves the block idle.
//  The 2-entry queue keeps the input accepting while results stall, until it fills.
// ----------------------------------------------------------------------------
module scaled_blit_address_generator #(
  parameter int MAX_DIM         = sbag_pkg::MAX_DIM_DEF,
  parameter int BYTES_PER_PIXEL = sbag_pkg::BPP_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // src_left, src_top, src_right, src_bottom, dst_left, dst_top, dst_right, dst_bottom
  input  logic [sbag_pkg::IN_DATA_W-1:0]    s_tdata,
  // command, same_surface
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // src_offset, dst_offset
  output logic [sbag_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status
  output logic [sbag_pkg::STATUS_W-1:0]     m_tuser,
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbag_pkg::CFG_DATA_W-1:0]   cfg_data
);

  sbag_pkg::cfg_t   cfg;
  sbag_pkg::entry_t q_in, q_out;
  logic q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width  <= sbag_pkg::DIM_W'(640);
      cfg.src_height <= sbag_pkg::DIM_W'(480);
      cfg.src_stride <= sbag_pkg::STRIDE_W'(1920);
      cfg.src_format <= sbag_pkg::FMT_W'(2);
      cfg.dst_width  <= sbag_pkg::DIM_W'(640);
      cfg.dst_height <= sbag_pkg::DIM_W'(480);
      cfg.dst_stride <= sbag_pkg::STRIDE_W'(1920);
      cfg.dst_format <= sbag_pkg::FMT_W'(2);
    end else if (cfg_valid) begin
      case (sbag_pkg::reg_idx_t'(cfg_index))
        sbag_pkg::REG_SRC_WIDTH:  cfg.src_width  <= cfg_data[sbag_pkg::DIM_W-1:0];
        sbag_pkg::REG_SRC_HEIGHT: cfg.src_height <= cfg_data[sbag_pkg::DIM_W-1:0];
        sbag_pkg::REG_SRC_STRIDE: cfg.src_stride <= cfg_data;
        sbag_pkg::REG_SRC_FORMAT: cfg.src_format <= cfg_data[sbag_pkg::FMT_W-1:0];
        sbag_pkg::REG_DST_WIDTH:  cfg.dst_width  <= cfg_data[sbag_pkg::DIM_W-1:0];
        sbag_pkg::REG_DST_HEIGHT: cfg.dst_height <= cfg_data[sbag_pkg::DIM_W-1:0];
        sbag_pkg::REG_DST_STRIDE: cfg.dst_stride <= cfg_data;
        sbag_pkg::REG_DST_FORMAT: cfg.dst_format <= cfg_data[sbag_pkg::FMT_W-1:0];
        default: ;
      endcase
    end
  end

  sbag_front #(.MAX_DIM(MAX_DIM)) u_front (
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .cfg(cfg), .q_full(q_full), .q_push(q_push), .q_entry(q_in)
  );

  sbag_fifo #(.DEPTH(sbag_pkg::QDEPTH)) u_fifo (
    .clk(clk), .rst(rst), .push(q_push), .din(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .dout(q_out)
  );

  sbag_back #(.BYTES_PER_PIXEL(BYTES_PER_PIXEL)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_empty(q_empty), .q_head(q_out), .q_pop(q_pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

endmodule

// ----- hdl/sbag_div.sv -----
// ----------------------------------------------------------------------------
// sbag_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbag_div #(
  parameter int W = sbag_pkg::DIM_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q;
  logic [W:0]    r;
  logic [W-1:0]  den_r;
  logic [CW-1:0] cnt;
  logic [W:0]    trial;
  logic          ge;

  assign trial = {r[W-1:0], q[W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign quo   = q;
  assign rem   = r[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      q     <= num;
      r     <= '0;
      den_r <= den;
      cnt   <= CW'(W);
      busy  <= 1'b1;
    end else if (busy) begin
      r   <= ge ? trial - {1'b0, den_r} : trial;
      q   <= {q[W-2:0], ge};
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

endmodule

// ----- hdl/sbag_front.sv -----
// ----------------------------------------------------------------------------
// sbag_front
// Accepts commands, clamps both rectangles and classifies start commands.
// ----------------------------------------------------------------------------
module sbag_front #(
  parameter int MAX_DIM = sbag_pkg::MAX_DIM_DEF
) (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [sbag_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic [1:0]                     s_tuser,
  input  sbag_pkg::cfg_t                 cfg,
  input  logic                           q_full,
  output logic                           q_push,
  output sbag_pkg::entry_t               q_entry
);

  localparam int CW = sbag_pkg::COORD_W;

  logic [sbag_pkg::DIM_W:0] sw, sh, dw, dh;
  sbag_pkg::coord_t sl, st, sr, sb, dl, dt, dr, db;
  logic mismatch, empty_s, empty_d, copy;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    sw = sbag_pkg::dim_of(cfg.src_width, MAX_DIM);
    sh = sbag_pkg::dim_of(cfg.src_height, MAX_DIM);
    dw = sbag_pkg::dim_of(cfg.dst_width, MAX_DIM);
    dh = sbag_pkg::dim_of(cfg.dst_height, MAX_DIM);
    sl = sbag_pkg::clamp_lo(s_tdata[0*CW +: CW]);
    st = sbag_pkg::clamp_lo(s_tdata[1*CW +: CW]);
    sr = sbag_pkg::clamp_hi(s_tdata[2*CW +: CW], sw);
    sb = sbag_pkg::clamp_hi(s_tdata[3*CW +: CW], sh);
    dl = sbag_pkg::clamp_lo(s_tdata[4*CW +: CW]);
    dt = sbag_pkg::clamp_lo(s_tdata[5*CW +: CW]);
    dr = sbag_pkg::clamp_hi(s_tdata[6*CW +: CW], dw);
    db = sbag_pkg::clamp_hi(s_tdata[7*CW +: CW], dh);
    mismatch = cfg.src_format != cfg.dst_format;
    empty_s  = (sl > sr) || (st > sb);
    empty_d  = (dl > dr) || (dt > db);
    copy     = s_tuser[1];

    q_entry.copy     = copy;
    // same-surface overlap direction
    q_entry.rows_rev = copy && (dt > st) && (dt < sb);
    q_entry.cols_rev = copy && (dl > sl);
    q_entry.sl = sl;
    q_entry.st = st;
    q_entry.sr = sr;
    q_entry.sb = sb;
    q_entry.dl = dl;
    q_entry.dt = dt;
    q_entry.dr = dr;
    q_entry.db = db;
    if (s_tuser[0]) begin
      q_entry.kind = sbag_pkg::K_STEP;
    end else if (mismatch) begin
      q_entry.kind = sbag_pkg::K_MISMATCH;
    end else if (empty_s || (!copy && empty_d)) begin
      q_entry.kind = sbag_pkg::K_EMPTY;
    end else begin
      q_entry.kind = sbag_pkg::K_START;
    end
  end

endmodule

// ----- hdl/sbag_fifo.sv -----
// ----------------------------------------------------------------------------
// sbag_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module sbag_fifo #(
  parameter int DEPTH = sbag_pkg::QDEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sbag_pkg::entry_t din,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output sbag_pkg::entry_t dout
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  sbag_pkg::entry_t mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [NW-1:0] count;

  assign full  = count == NW'(DEPTH);
  assign empty = count == '0;
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      if (pop)  rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      if (push && !pop) count <= count + NW'(1);
      else if (pop && !push) count <= count - NW'(1);
    end
  end

endmodule

// ----- hdl/sbag_back.sv -----
// ----------------------------------------------------------------------------
// sbag_back
// Runs blits: start setup with ratio divides, Bresenham stepping, offsets.
// ----------------------------------------------------------------------------
module sbag_back #(
  parameter int BYTES_PER_PIXEL = sbag_pkg::BPP_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sbag_pkg::cfg_t                  cfg,
  input  logic                            q_empty,
  input  sbag_pkg::entry_t                q_head,
  output logic                            q_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sbag_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [sbag_pkg::STATUS_W-1:0]   m_tuser,
  output logic                            m_tlast
);

  localparam int PW = sbag_pkg::POS_W;
  localparam int DW = sbag_pkg::DIM_W;
  localparam int XW = sbag_pkg::PROD_W;
  localparam int OW = sbag_pkg::OFF_W;

  sbag_pkg::bstate_t state, state_next;
  logic out_free, div_start, h_busy, v_busy;
  logic active, copy, rrev, crev;
  sbag_pkg::coord_t c_sl, c_st, c_sr, c_sb, c_dl, c_dt, c_dr, c_db;
  logic [PW-1:0] dcol, drow, scol, srow;
  logic [DW-1:0] he, ve, dw, dh, qh, rh, qv, rv;
  logic signed [PW:0] sw_w, sh_w, dw_w, dh_w;

  logic [PW-1:0] sl_u, st_u, sr_u, sb_u, dl_u, dt_u, dr_u, db_u;
  logic [PW-1:0] row_start, row_end, last_row, cp_dc, cp_dr, rd, cd;
  logic [PW:0]   cp_dc_w, cp_dr_w;
  logic [DW:0]   hsum, vsum;
  logic          hcarry, vcarry, fin;
  logic [sbag_pkg::STRIDE_W-1:0] stride_s;
  logic [XW-1:0] mul_s, mul_d;

  logic [XW-1:0] prod_s, prod_d;
  logic [PW-1:0] col_s, col_d;
  logic          fin_r;
  logic [XW-1:0] off_s, off_d;

  assign out_free = !m_tvalid || m_tready;

  // start-time ratio sizes from the queue head
  assign sw_w = q_head.sr - q_head.sl + (PW+1)'(1);
  assign sh_w = q_head.sb - q_head.st + (PW+1)'(1);
  assign dw_w = q_head.dr - q_head.dl + (PW+1)'(1);
  assign dh_w = q_head.db - q_head.dt + (PW+1)'(1);

  sbag_div #(.W(DW)) u_hdiv (
    .clk(clk), .rst(rst), .start(div_start),
    .num(DW'(sw_w)), .den(DW'(dw_w)),
    .busy(h_busy), .quo(qh), .rem(rh)
  );

  sbag_div #(.W(DW)) u_vdiv (
    .clk(clk), .rst(rst), .start(div_start),
    .num(DW'(sh_w)), .den(DW'(dh_w)),
    .busy(v_busy), .quo(qv), .rem(rv)
  );

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    case (state)
      sbag_pkg::B_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          if (q_head.kind == sbag_pkg::K_STEP && active) begin
            state_next = sbag_pkg::B_ADDR;
          end else if (q_head.kind == sbag_pkg::K_START && !q_head.copy) begin
            div_start  = 1'b1;
            state_next = sbag_pkg::B_DIV;
          end
        end
      end
      sbag_pkg::B_DIV: begin
        if (!h_busy && !v_busy) state_next = sbag_pkg::B_IDLE;
      end
      sbag_pkg::B_ADDR: begin
        state_next = sbag_pkg::B_IDLE;
      end
      default: begin
        state_next = sbag_pkg::B_IDLE;
      end
    endcase
  end

  // clamped corners are non-negative wherever a running blit reads them
  always_comb begin
    sl_u = c_sl;
    st_u = c_st;
    sr_u = c_sr;
    sb_u = c_sb;
    dl_u = c_dl;
    dt_u = c_dt;
    dr_u = c_dr;
    db_u = c_db;
    row_start = crev ? sr_u : sl_u;
    row_end   = crev ? sl_u : sr_u;
    last_row  = rrev ? st_u : sb_u;
    cp_dc_w   = {1'b0, dl_u} + {1'b0, scol} - {1'b0, sl_u};
    cp_dr_w   = {1'b0, dt_u} + {1'b0, srow} - {1'b0, st_u};
    cp_dc     = cp_dc_w[PW-1:0];
    cp_dr     = cp_dr_w[PW-1:0];
    hsum      = {1'b0, he} + {1'b0, rh};
    vsum      = {1'b0, ve} + {1'b0, rv};
    hcarry    = hsum >= {1'b0, dw};
    vcarry    = vsum >= {1'b0, dh};
    fin       = copy ? (scol == row_end && srow == last_row)
                     : (dcol == dr_u && drow == db_u);
    rd        = copy ? cp_dr : drow;
    cd        = copy ? cp_dc : dcol;
    stride_s  = copy ? cfg.dst_stride : cfg.src_stride;
    mul_s     = srow * stride_s;
    mul_d     = rd * cfg.dst_stride;
    off_s     = prod_s + XW'(col_s) * XW'(BYTES_PER_PIXEL);
    off_d     = prod_d + XW'(col_d) * XW'(BYTES_PER_PIXEL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sbag_pkg::B_IDLE;
      active   <= 1'b0;
      copy     <= 1'b0;
      rrev     <= 1'b0;
      crev     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      if (q_pop) begin
        case (q_head.kind)
          sbag_pkg::K_MISMATCH, sbag_pkg::K_EMPTY: begin
            active   <= 1'b0;
            m_tvalid <= 1'b1;
            m_tuser  <= (q_head.kind == sbag_pkg::K_MISMATCH) ? sbag_pkg::ST_MISMATCH
                                                              : sbag_pkg::ST_EMPTY;
            m_tdata  <= '0;
            m_tlast  <= 1'b0;
          end
          sbag_pkg::K_START: begin
            active <= 1'b1;
            copy   <= q_head.copy;
            rrev   <= q_head.rows_rev;
            crev   <= q_head.cols_rev;
            c_sl <= q_head.sl;
            c_st <= q_head.st;
            c_sr <= q_head.sr;
            c_sb <= q_head.sb;
            c_dl <= q_head.dl;
            c_dt <= q_head.dt;
            c_dr <= q_head.dr;
            c_db <= q_head.db;
            he <= '0;
            ve <= '0;
            dw <= DW'(dw_w);
            dh <= DW'(dh_w);
            if (q_head.copy) begin
              srow <= q_head.rows_rev ? q_head.sb : q_head.st;
              scol <= q_head.cols_rev ? q_head.sr : q_head.sl;
            end else begin
              srow <= q_head.st;
              scol <= q_head.sl;
              drow <= q_head.dt;
              dcol <= q_head.dl;
            end
            m_tvalid <= 1'b1;
            m_tuser  <= sbag_pkg::ST_STARTED;
            m_tdata  <= '0;
            m_tlast  <= 1'b0;
          end
          sbag_pkg::K_STEP: begin
            if (!active) begin
              m_tvalid <= 1'b1;
              m_tuser  <= sbag_pkg::ST_IDLE;
              m_tdata  <= '0;
              m_tlast  <= 1'b0;
            end else begin
              prod_s <= mul_s;
              prod_d <= mul_d;
              col_s  <= scol;
              col_d  <= cd;
              fin_r  <= fin;
              if (fin) begin
                active <= 1'b0;
              end else if (copy) begin
                if (scol == row_end) begin
                  scol <= row_start;
                  srow <= rrev ? srow - PW'(1) : srow + PW'(1);
                end else begin
                  scol <= crev ? scol - PW'(1) : scol + PW'(1);
                end
              end else if (dcol == dr_u) begin
                dcol <= dl_u;
                drow <= drow + PW'(1);
                scol <= sl_u;
                he   <= '0;
                ve   <= vcarry ? DW'(vsum - {1'b0, dh}) : DW'(vsum);
                srow <= srow + PW'(qv) + PW'(vcarry);
              end else begin
                dcol <= dcol + PW'(1);
                he   <= hcarry ? DW'(hsum - {1'b0, dw}) : DW'(hsum);
                scol <= scol + PW'(qh) + PW'(hcarry);
              end
            end
          end
          default: ;
        endcase
      end

      if (state == sbag_pkg::B_ADDR) begin
        m_tvalid <= 1'b1;
        m_tuser  <= sbag_pkg::ST_PAIR;
        m_tdata  <= {off_d[OW-1:0], off_s[OW-1:0]};
        m_tlast  <= fin_r;
      end
    end
  end

endmodule

// ----- tb/sbag_checker.sv -----
// ----------------------------------------------------------------------------
// sbag_checker
// Watches the config, input and output channels of the blit address
// generator. Predicts each result from accepted items and compares it.
// ----------------------------------------------------------------------------
module sbag_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [sbag_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic [1:0]                        s_tuser,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [sbag_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic [sbag_pkg::STATUS_W-1:0]     m_tuser,
  input  logic                              m_tlast,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [sbag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbag_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                errors,
  output int                                pending,
  output int                                pairs_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    sbag_pkg::status_t          st;
    logic [sbag_pkg::OFF_W-1:0] soff;
    logic [sbag_pkg::OFF_W-1:0] doff;
    logic                       lst;
  } addr_pair_t;

  addr_pair_t exp_q[$];
  logic [15:0] reg_val[8];

  bit blit_on, copy_on, rows_rev, cols_rev;
  int dcol, drow, scol, srow, herr, verr;
  int crect[8];

  function automatic int eff_dim(int r);
    return (r > sbag_pkg::MAX_DIM_DEF) ? sbag_pkg::MAX_DIM_DEF : r;
  endfunction

  function automatic logic [sbag_pkg::OFF_W-1:0] byte_off(int row, int col, int stride);
    logic [63:0] o;
    o = {32'd0, row} * stride + {32'd0, col} * sbag_pkg::BPP_DEF;
    return o[sbag_pkg::OFF_W-1:0];
  endfunction

  function automatic void load_defaults();
    reg_val[sbag_pkg::REG_SRC_WIDTH]  = 640;
    reg_val[sbag_pkg::REG_SRC_HEIGHT] = 480;
    reg_val[sbag_pkg::REG_SRC_STRIDE] = 1920;
    reg_val[sbag_pkg::REG_SRC_FORMAT] = 2;
    reg_val[sbag_pkg::REG_DST_WIDTH]  = 640;
    reg_val[sbag_pkg::REG_DST_HEIGHT] = 480;
    reg_val[sbag_pkg::REG_DST_STRIDE] = 1920;
    reg_val[sbag_pkg::REG_DST_FORMAT] = 2;
    blit_on = 0; copy_on = 0; rows_rev = 0; cols_rev = 0;
    dcol = 0; drow = 0; scol = 0; srow = 0; herr = 0; verr = 0;
    for (int i = 0; i < 8; i++) crect[i] = 0;
  endfunction

  function automatic void clip_rect(int b, int w, int h);
    if (crect[b] < 0) crect[b] = 0;
    if (crect[b+1] < 0) crect[b+1] = 0;
    if (crect[b+2] >= w) crect[b+2] = w - 1;
    if (crect[b+3] >= h) crect[b+3] = h - 1;
  endfunction

  function automatic sbag_pkg::status_t begin_blit(bit same,
                                                   logic [sbag_pkg::IN_DATA_W-1:0] d);
    blit_on = 0;
    if (reg_val[sbag_pkg::REG_SRC_FORMAT] != reg_val[sbag_pkg::REG_DST_FORMAT])
      return sbag_pkg::ST_MISMATCH;
    for (int i = 0; i < 8; i++)
      crect[i] = int'($signed(d[i*sbag_pkg::COORD_W +: sbag_pkg::COORD_W]));
    clip_rect(0, eff_dim(reg_val[sbag_pkg::REG_SRC_WIDTH]),
              eff_dim(reg_val[sbag_pkg::REG_SRC_HEIGHT]));
    clip_rect(4, eff_dim(reg_val[sbag_pkg::REG_DST_WIDTH]),
              eff_dim(reg_val[sbag_pkg::REG_DST_HEIGHT]));
    copy_on = same;
    if (crect[0] > crect[2] || crect[1] > crect[3]) return sbag_pkg::ST_EMPTY;
    if (copy_on) begin
      rows_rev = crect[5] > crect[1] && crect[5] < crect[3];
      cols_rev = crect[4] > crect[0];
      srow = rows_rev ? crect[3] : crect[1];
      scol = cols_rev ? crect[2] : crect[0];
    end else begin
      if (crect[4] > crect[6] || crect[5] > crect[7]) return sbag_pkg::ST_EMPTY;
      rows_rev = 0; cols_rev = 0;
      dcol = crect[4]; drow = crect[5];
      scol = crect[0]; srow = crect[1];
    end
    herr = 0; verr = 0;
    blit_on = 1;
    return sbag_pkg::ST_STARTED;
  endfunction

  function automatic addr_pair_t next_pair();
    addr_pair_t p;
    int rs, re, lr, dc, dr, sw, sh, dw, dh;
    bit fin;
    p = '{st: sbag_pkg::ST_PAIR, soff: '0, doff: '0, lst: 1'b0};
    if (!blit_on) begin
      p.st = sbag_pkg::ST_IDLE;
      return p;
    end
    if (copy_on) begin
      rs = cols_rev ? crect[2] : crect[0];
      re = cols_rev ? crect[0] : crect[2];
      lr = rows_rev ? crect[1] : crect[3];
      dc = crect[4] + (scol - crect[0]);
      dr = crect[5] + (srow - crect[1]);
      fin = scol == re && srow == lr;
      p.soff = byte_off(srow, scol, reg_val[sbag_pkg::REG_DST_STRIDE]);
      p.doff = byte_off(dr, dc, reg_val[sbag_pkg::REG_DST_STRIDE]);
      p.lst = fin;
      if (fin) blit_on = 0;
      else if (scol == re) begin
        scol = rs;
        srow += rows_rev ? -1 : 1;
      end else scol += cols_rev ? -1 : 1;
    end else begin
      sw = crect[2] - crect[0] + 1;
      sh = crect[3] - crect[1] + 1;
      dw = crect[6] - crect[4] + 1;
      dh = crect[7] - crect[5] + 1;
      fin = dcol == crect[6] && drow == crect[7];
      p.soff = byte_off(srow, scol, reg_val[sbag_pkg::REG_SRC_STRIDE]);
      p.doff = byte_off(drow, dcol, reg_val[sbag_pkg::REG_DST_STRIDE]);
      p.lst = fin;
      if (fin) blit_on = 0;
      else if (dcol == crect[6]) begin
        dcol = crect[4];
        drow += 1;
        scol = crect[0];
        herr = 0;
        verr += sh;
        srow += verr / dh;
        verr = verr % dh;
      end else begin
        dcol += 1;
        herr += sw;
        scol += herr / dw;
        herr = herr % dw;
      end
    end
    return p;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  assign pending = exp_q.size();

  always @(posedge clk) begin
    addr_pair_t p, e;
    if (rst) begin
      load_defaults();
      exp_q.delete();
      errors = 0;
      pairs_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sbag_pkg::REG_SRC_FORMAT, sbag_pkg::REG_DST_FORMAT:
            reg_val[cfg_index] = cfg_data & 16'h3;
          sbag_pkg::REG_SRC_STRIDE, sbag_pkg::REG_DST_STRIDE:
            reg_val[cfg_index] = cfg_data;
          default: reg_val[cfg_index] = cfg_data & 16'h1FFF;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (!s_tuser[0]) begin
          p = '{st: sbag_pkg::ST_PAIR, soff: '0, doff: '0, lst: 1'b0};
          p.st = begin_blit(s_tuser[1], s_tdata);
        end else p = next_pair();
        exp_q.push_back(p);
      end
      if (m_tvalid && m_tready) begin
        if (exp_q.size() == 0) begin
          report("unexpected item, status", m_tuser, -1);
        end else begin
          e = exp_q.pop_front();
          if (m_tuser != e.st) report("status", m_tuser, e.st);
          if (m_tdata[sbag_pkg::OFF_W-1:0] != e.soff)
            report("src_offset", m_tdata[sbag_pkg::OFF_W-1:0], e.soff);
          if (m_tdata[2*sbag_pkg::OFF_W-1:sbag_pkg::OFF_W] != e.doff)
            report("dst_offset", m_tdata[2*sbag_pkg::OFF_W-1:sbag_pkg::OFF_W], e.doff);
          if (m_tlast != e.lst) report("last", m_tlast, e.lst);
          if (e.st == sbag_pkg::ST_PAIR) pairs_seen++;
        end
      end
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random blit commands and register settings into the
// scaled blit address generator, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [sbag_pkg::IN_DATA_W-1:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid, m_tready;
  logic [sbag_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [sbag_pkg::STATUS_W-1:0] m_tuser;
  logic m_tlast;
  logic cfg_valid, cfg_ready;
  logic [sbag_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sbag_pkg::CFG_DATA_W-1:0] cfg_data;

  int errors, pending, pairs_seen;
  int send_idle_pct, recv_idle_pct;
  int hold_req, hold_seen, hold_left;
  int items_sent, settings_run;
  int cur_cfg[8];

  scaled_blit_address_generator dut (.*);

  sbag_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("scaled_blit_address_generator regression: fail");
    $finish;
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_item(bit cmd, bit same, int r[8]);
    logic [sbag_pkg::IN_DATA_W-1:0] d;
    bit rdy;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    for (int i = 0; i < 8; i++)
      d[i*sbag_pkg::COORD_W +: sbag_pkg::COORD_W] = r[i][sbag_pkg::COORD_W-1:0];
    s_tdata <= d;
    s_tuser <= {same, cmd};
    s_tvalid <= 1'b1;
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
    items_sent++;
  endtask

  task automatic steps(int n);
    int z[8];
    for (int i = 0; i < 8; i++) z[i] = $urandom;
    repeat (n) send_item(1'b1, 1'($urandom_range(0, 1)), z);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(sbag_pkg::reg_idx_t idx, int val);
    bit rdy;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cur_cfg[idx] = val & ((idx == sbag_pkg::REG_SRC_STRIDE ||
                           idx == sbag_pkg::REG_DST_STRIDE) ? 16'hFFFF :
                          (idx == sbag_pkg::REG_SRC_FORMAT ||
                           idx == sbag_pkg::REG_DST_FORMAT) ? 16'h3 : 16'h1FFF);
  endtask

  task automatic apply_setting(int v[8]);
    drain();
    for (int i = 0; i < 8; i++) write_reg(sbag_pkg::reg_idx_t'(i), v[i]);
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_run++;
  endtask

  // one corner pair along a surface axis, mostly small and near the surface
  task automatic pick_span(int dim, output int lo, output int hi);
    int d;
    d = (dim > sbag_pkg::MAX_DIM_DEF) ? sbag_pkg::MAX_DIM_DEF : dim;
    if ($urandom_range(0, 9) == 0) begin
      lo = int'($signed(14'($urandom)));
      hi = int'($signed(14'($urandom)));
    end else begin
      lo = int'($urandom_range(0, d + 4)) - 3;
      hi = lo + int'($urandom_range(0, 7)) - 1;
    end
  endtask

  task automatic random_traffic(int count);
    int r[8];
    int k, est, n;
    bit same, held;
    k = 0;
    held = 0;
    while (k < count) begin
      if (!held && k >= count / 2 && send_idle_pct == 59) begin
        hold_req++;
        held = 1;
      end
      if ($urandom_range(0, 99) < 8) begin
        for (int i = 0; i < 8; i++) r[i] = $urandom;
        send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), r);
        k++;
      end else begin
        same = ($urandom_range(0, 2) == 0);
        pick_span(cur_cfg[sbag_pkg::REG_SRC_WIDTH], r[0], r[2]);
        pick_span(cur_cfg[sbag_pkg::REG_SRC_HEIGHT], r[1], r[3]);
        if (same) begin
          r[4] = r[0] + int'($urandom_range(0, 4)) - 2;
          r[5] = r[1] + int'($urandom_range(0, 4)) - 2;
          r[6] = int'($urandom_range(0, 20)) - 2;
          r[7] = int'($urandom_range(0, 20)) - 2;
          est = (r[2] - r[0] + 1) * (r[3] - r[1] + 1);
        end else begin
          pick_span(cur_cfg[sbag_pkg::REG_DST_WIDTH], r[4], r[6]);
          pick_span(cur_cfg[sbag_pkg::REG_DST_HEIGHT], r[5], r[7]);
          est = (r[6] - r[4] + 1) * (r[7] - r[5] + 1);
        end
        if (est < 1) est = 1;
        if (est > 60) est = 60;
        send_item(1'b0, same, r);
        n = ($urandom_range(0, 99) < 85) ? est + int'($urandom_range(0, 2))
                                          : int'($urandom_range(0, est));
        steps(n);
        k += 1 + n;
      end
    end
  endtask

  initial begin
    int r[8];
    int v[8];
    rst = 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    send_idle_pct = 31;
    recv_idle_pct = 59;
    hold_req = 0;
    items_sent = 0;
    settings_run = 0;
    cur_cfg = '{640, 480, 1920, 2, 640, 480, 1920, 2};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // step while idle, then a small upscale
    steps(1);
    r = '{0, 0, 1, 1, 5, 5, 7, 6};
    send_item(1'b0, 1'b0, r);
    steps(7);
    // same-surface copy overlapping down and right
    r = '{2, 2, 3, 4, 3, 3, 9, 9};
    send_item(1'b0, 1'b1, r);
    steps(6);
    // empty source
    r = '{5, 0, 4, 3, 0, 0, 3, 3};
    send_item(1'b0, 1'b0, r);
    // extreme corners clamp to the whole surface; restart while active
    r = '{-8192, -8192, 8191, 8191, -8192, -8192, 8191, 8191};
    send_item(1'b0, 1'b0, r);
    steps(2);
    r = '{-8192, 0, 0, 0, 0, 0, 0, 0};
    send_item(1'b0, 1'b1, r);
    steps(2);

    v = '{640, 480, 1920, 2, 640, 480, 1920, 2};
    apply_setting(v);
    random_traffic(90);
    v = '{1, 1, 3, 0, 1, 1, 3, 0};
    apply_setting(v);
    random_traffic(80);
    v = '{8191, 4096, 65535, 3, 4096, 8191, 65535, 3};
    apply_setting(v);
    random_traffic(100);

    send_idle_pct = 59;
    recv_idle_pct = 31;
    v = '{0, 16, 100, 1, 16, 0, 100, 1};
    apply_setting(v);
    random_traffic(60);
    v = '{20, 20, 60, 1, 20, 20, 60, 2};
    apply_setting(v);
    random_traffic(60);
    v = '{$urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(3, 65535), 1,
          $urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(3, 65535), 1};
    apply_setting(v);
    random_traffic(120);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    v = '{$urandom_range(1, 64), $urandom_range(1, 64), $urandom, 3,
          $urandom_range(1, 64), $urandom_range(1, 64), $urandom, 3};
    apply_setting(v);
    random_traffic(110);
    v = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    apply_setting(v);
    random_traffic(60);

    drain();
    $display("covered %0d items over %0d register settings, %0d pixel pairs checked",
             items_sent, settings_run, pairs_seen);
    $display("scaling and same-surface blits, clamping, empty, mismatch and idle steps");
    if (errors == 0) begin
      $display("scaled_blit_address_generator regression: pass");
    end else begin
      $display("scaled_blit_address_generator regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/sbag_pkg.sv
hdl/sbag_div.sv
hdl/sbag_front.sv
hdl/sbag_fifo.sv
hdl/sbag_back.sv
hdl/scaled_blit_address_generator.sv
tb/sbag_checker.sv
tb/tb_top.sv
